/* sv/lfps_pkg.sv */
// Shared types, widths and flare element constants for the lens flare pixel shader.
package lfps_pkg;

  // Offsets between a pixel centre and an element centre, in 1/4096 pixel.
  localparam int DW = 28;
  // Offsets that passed the bounding box test of the largest element.
  localparam int CW = 19;
  localparam int SUB_BITS = 12;
  // Root bits of the disc distance: 16 * 38 * 4096 stays below 2**22.
  localparam int RB = 22;
  localparam int ISQRT_STEPS = RB;
  // Shape unit: three front stages, the root steps, four falloff stages.
  localparam int SHAPE_LAT = 3 + ISQRT_STEPS + 4;
  // Accept to result: input, centre and offset stages, shape unit, two sum stages.
  localparam int PIPE_LAT = 3 + SHAPE_LAT + 2;
  localparam int HEX_S3 = 56756;

  localparam int GHOST_SLOTS = 6;
  localparam int GHOST_S [GHOST_SLOTS] = '{56, 115, 179, 256, 328, 397};
  localparam int GHOST_R [GHOST_SLOTS] = '{10, 16, 8, 22, 11, 7};
  localparam int GHOST_PEAK [GHOST_SLOTS] = '{90, 55, 70, 40, 50, 80};
  localparam bit GHOST_HEX [GHOST_SLOTS] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  // ceil(2**32 / R): exact floor division by R for dividends below 2**22.
  localparam longint GHOST_RECIP [GHOST_SLOTS] = '{
    429496730, 268435456, 536870912, 195225787, 390451573, 613566757};

  localparam int HALO_R = 38;
  localparam int HALO_PEAK = 70;
  localparam longint HALO_RECIP = 113025456;
  localparam int CORE_R = 14;
  localparam int CORE_PEAK = 220;
  localparam longint CORE_RECIP = 306783379;

  typedef logic signed [DW-1:0] offset_t;

  typedef enum logic {
    REG_LIGHT_X = 1'b0,
    REG_LIGHT_Y = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic       valid;
    logic [9:0] x;
    logic [8:0] y;
    logic [7:0] base;
    logic       on;
  } item_t;

endpackage

/* sv/lfps_shape.sv */
// One flare element (disc or hexagon) with squared falloff, fully pipelined.
module lfps_shape #(
  parameter int     RADIUS = 10,
  parameter int     PEAK   = 90,
  parameter bit     IS_HEX = 1'b0,
  parameter longint RECIP  = 429496730
) (
  input  logic            clk,
  input  lfps_pkg::offset_t dx,
  input  lfps_pkg::offset_t dy,
  output logic [7:0]      add
);
  import lfps_pkg::*;

  localparam int LIM  = RADIUS << SUB_BITS;
  localparam int LIMY = IS_HEX ? 2 * LIM : LIM;
  localparam logic [DW-1:0] LIM_V  = DW'(LIM);
  localparam logic [DW-1:0] LIMY_V = DW'(LIMY);
  localparam logic [36:0] LIM2_V = 37'(longint'(LIM) * longint'(LIM));
  localparam logic [36:0] MLIM_V = 37'(longint'(LIM) * 64'd65536);
  localparam logic [29:0] RECIP_V = 30'(RECIP);
  localparam logic [7:0] PEAK_V = 8'(PEAK);

  logic [DW-1:0] absx, absy;
  logic inb;
  assign absx = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign absy = dy[DW-1] ? DW'(-dy) : DW'(dy);
  assign inb  = (absx < LIM_V) && (absy < LIMY_V);

  // Stage 1: bounding box; offsets outside it are zeroed to keep widths small.
  logic s1_in;
  logic signed [CW-1:0] s1_dx, s1_dy;
  always_ff @(posedge clk) begin
    s1_in <= inb;
    s1_dx <= inb ? dx[CW-1:0] : '0;
    s1_dy <= inb ? dy[CW-1:0] : '0;
  end

  logic [RB-1:0] n_fin;
  logic in_fin;

  if (IS_HEX) begin : g_hex
    localparam logic signed [17:0] S3_V = 18'(HEX_S3);
    localparam int HD = ISQRT_STEPS - 1;

    logic signed [36:0] s2_pdy;
    logic signed [CW-1:0] s2_dx;
    logic s2_in;
    always_ff @(posedge clk) begin
      s2_pdy <= 37'(s1_dy * S3_V);
      s2_dx  <= s1_dx;
      s2_in  <= s1_in;
    end

    logic signed [36:0] dx32, bs, cs;
    logic [CW-1:0] adx;
    assign dx32 = {{3{s2_dx[CW-1]}}, s2_dx, 15'b0};
    assign bs   = s2_pdy + dx32;
    assign cs   = s2_pdy - dx32;
    assign adx  = s2_dx[CW-1] ? CW'(-s2_dx) : CW'(s2_dx);

    logic [36:0] s3_a, s3_b, s3_c;
    logic s3_in;
    always_ff @(posedge clk) begin
      s3_a  <= {2'b0, adx, 16'b0};
      s3_b  <= bs[36] ? 37'(-bs) : 37'(bs);
      s3_c  <= cs[36] ? 37'(-cs) : 37'(cs);
      s3_in <= s2_in;
    end

    logic [36:0] m_ab, m;
    assign m_ab = (s3_b > s3_a) ? s3_b : s3_a;
    assign m    = (s3_c > m_ab) ? s3_c : m_ab;

    // Distance is ready early; hold it until the disc path would finish.
    logic [RB-1:0] hd_n [0:HD];
    logic hd_in [0:HD];
    always_ff @(posedge clk) begin
      hd_n[0]  <= m[RB+11:12];
      hd_in[0] <= s3_in && (m < MLIM_V);
      for (int j = 1; j <= HD; j++) begin
        hd_n[j]  <= hd_n[j-1];
        hd_in[j] <= hd_in[j-1];
      end
    end
    assign n_fin  = hd_n[HD];
    assign in_fin = hd_in[HD];
  end else begin : g_disc
    logic [35:0] s2_sqx, s2_sqy;
    logic s2_in;
    always_ff @(posedge clk) begin
      s2_sqx <= 36'(s1_dx * s1_dx);
      s2_sqy <= 36'(s1_dy * s1_dy);
      s2_in  <= s1_in;
    end

    logic [36:0] r2;
    assign r2 = {1'b0, s2_sqx} + {1'b0, s2_sqy};

    // Digit-by-digit square root of 256 * r2, one root bit per stage.
    logic [RB:0]     rt_rem  [0:RB];
    logic [RB-1:0]   rt_root [0:RB];
    logic [2*RB-1:0] rt_val  [0:RB];
    logic            rt_in   [0:RB];

    always_ff @(posedge clk) begin
      rt_rem[0]  <= '0;
      rt_root[0] <= '0;
      rt_val[0]  <= {r2[35:0], 8'b0};
      rt_in[0]   <= s2_in && (r2 < LIM2_V);
    end

    for (genvar k = 0; k < RB; k++) begin : g_step
      logic [RB+2:0] rem2, trial;
      logic ge;
      assign rem2  = {rt_rem[k], rt_val[k][2*RB-1 -: 2]};
      assign trial = {1'b0, rt_root[k], 2'b01};
      assign ge    = rem2 >= trial;
      always_ff @(posedge clk) begin
        rt_rem[k+1]  <= ge ? (RB+1)'(rem2 - trial) : rem2[RB:0];
        rt_root[k+1] <= {rt_root[k][RB-2:0], ge};
        rt_val[k+1]  <= rt_val[k] << 2;
        rt_in[k+1]   <= rt_in[k];
      end
    end
    assign n_fin  = rt_root[RB];
    assign in_fin = rt_in[RB];
  end

  // Falloff: d = n / R by reciprocal, then peak * (1 - d)^2.
  logic [51:0] t_prod;
  logic t_in;
  always_ff @(posedge clk) begin
    t_prod <= n_fin * RECIP_V;
    t_in   <= in_fin;
  end

  logic [19:0] q;
  logic [15:0] d;
  assign q = t_prod[51:32];
  assign d = (q > 20'd65535) ? 16'hFFFF : q[15:0];

  logic [16:0] t;
  logic [33:0] tt;
  logic [41:0] pk;
  always_ff @(posedge clk) begin
    t  <= t_in ? (17'h10000 - {1'b0, d}) : '0;
    tt <= t * t;
  end
  assign pk = PEAK_V * tt;
  always_ff @(posedge clk) begin
    add <= pk[39:32];
  end

endmodule

/* sv/lens_flare_pixel_shader.sv */
// Top level of the lens flare pixel shader: pixel pipeline, streak and final sum.
//
//  Channel  | Ports                                  | Handshake
//  ---------+----------------------------------------+------------------------------
//  pixel in | pixel_x, pixel_y, base_value           | start high, busy low
//  result   | out_x, out_y, out_value                | done high for one cycle
//  config   | cfg_index, cfg_data                    | cfg_we high, no wait
//
// One pixel transaction is taken every clock cycle while start is high and busy
// is low; its result leaves through stages A to C, the shape units and both sum
// stages. The depth is set by the 22-step square-root pipeline in each disc unit;
// the hexagon units and the streak divider are padded to match.
// Reset is synchronous, loads the light position 5120, 3840 in 1/16 pixel and
// clears all valid bits; busy is high only while rst is high. The receiver
// cannot stall, so nothing in the pipeline ever waits.
module lens_flare_pixel_shader #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480,
  parameter int GHOST_COUNT   = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [9:0]         pixel_x,
  input  logic [8:0]         pixel_y,
  input  logic [7:0]         base_value,
  input  logic               cfg_we,
  input  lfps_pkg::cfg_reg_t cfg_index,
  input  logic [13:0]        cfg_data,
  output logic               done,
  output logic [9:0]         out_x,
  output logic [8:0]         out_y,
  output logic [7:0]         out_value
);
  import lfps_pkg::*;

  localparam int NG = (GHOST_COUNT < GHOST_SLOTS) ? GHOST_COUNT : GHOST_SLOTS;
  localparam logic [12:0] SW_V = 13'(SCREEN_WIDTH);
  localparam logic [12:0] SH_V = 13'(SCREEN_HEIGHT);
  // Screen centre in 1/16 pixel and in 1/4096 pixel.
  localparam logic signed [17:0] CX16_V = 18'(SCREEN_WIDTH * 8);
  localparam logic signed [17:0] CY16_V = 18'(SCREEN_HEIGHT * 8);
  localparam logic signed [DW-1:0] CXC_V = DW'(SCREEN_WIDTH * 2048);
  localparam logic signed [DW-1:0] CYC_V = DW'(SCREEN_HEIGHT * 2048);
  localparam int SD_DELAY = SHAPE_LAT - 5;

  // Light position registers. The user must change them only while no pixel is in
  // flight (the block does not enforce it), so every stage may read them directly.
  logic [13:0] light_x;
  logic [12:0] light_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= 14'd5120;
      light_y <= 13'd3840;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIGHT_X: light_x <= cfg_data;
        REG_LIGHT_Y: light_y <= cfg_data[12:0];
      endcase
    end
  end

  assign busy = rst;

  // Stage A: input register. The on-screen flag decides whether any light is
  // added at all.
  item_t a_item;
  always_ff @(posedge clk) begin
    a_item.x    <= pixel_x;
    a_item.y    <= pixel_y;
    a_item.base <= base_value;
    a_item.on   <= ({3'b0, pixel_x} < SW_V) && ({4'b0, pixel_y} < SH_V);
    if (rst) begin
      a_item.valid <= 1'b0;
    end else begin
      a_item.valid <= start && !busy;
    end
  end

  // Stage B: pixel centre, ghost centre products and streak row terms.
  logic signed [17:0] ldx, ldy;
  assign ldx = CX16_V - $signed({4'b0, light_x});
  assign ldy = CY16_V - $signed({5'b0, light_y});

  // The streak covers rows floor(ly)-3 through ceil(ly)+3.
  logic [8:0] row_top;
  logic [13:0] ly_up;
  logic in_row;
  logic signed [14:0] er;
  logic [14:0] ae;
  logic signed [15:0] fr;
  logic [15:0] af;
  assign row_top = light_y[12:4];
  assign ly_up   = {1'b0, light_y} + 14'd15;
  assign in_row  = ({2'b0, a_item.y} + 11'd3 >= {2'b0, row_top}) &&
                   ({2'b0, a_item.y} <= {1'b0, ly_up[13:4]} + 11'd3);
  assign er = $signed({2'b0, a_item.y, 4'h8}) - $signed({2'b0, light_y});
  assign ae = er[14] ? 15'(-er) : 15'(er);
  assign fr = $signed({2'b0, a_item.x, 4'h8}) - $signed({2'b0, light_x});
  assign af = fr[15] ? 16'(-fr) : 16'(fr);

  item_t b_item;
  offset_t b_px, b_py;
  logic signed [7:0] b_e;
  logic [14:0] b_f;
  always_ff @(posedge clk) begin
    if (rst) begin
      b_item <= '0;
    end else begin
      b_item <= a_item;
    end
    b_px   <= DW'({a_item.x, 12'h800});
    b_py   <= DW'({a_item.y, 12'h800});
    b_e    <= in_row ? (8'sd56 - $signed({1'b0, ae[6:0]})) : 8'sd0;
    b_f    <= af[14:0];
  end

  // Stage C: offsets to each element centre, streak numerator and denominator.
  item_t c_item;
  offset_t c_ldx, c_ldy;
  logic [15:0] esq;
  logic [17:0] den7;
  assign esq  = 16'(b_e * b_e);
  assign den7 = {b_f, 3'b0} - {3'b0, b_f} + 18'd3136;

  logic [15:0] sd_rem [0:5];
  logic [16:0] sd_den [0:5];
  logic [4:0]  sd_q   [0:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_item <= '0;
    end else begin
      c_item <= b_item;
    end
    c_ldx     <= b_px - $signed(DW'({light_x, 8'b0}));
    c_ldy     <= b_py - $signed(DW'({light_y, 8'b0}));
    sd_rem[0] <= {esq[11:0], 4'b0} + {3'b0, esq[11:0], 1'b0};
    sd_den[0] <= den7[16:0];
    sd_q[0]   <= '0;
  end

  // Streak brightness 18 e^2 / (7 (448 + f)) is at most 18, so a five-stage
  // restoring divider gives the exact quotient.
  for (genvar k = 0; k < 5; k++) begin : g_sdiv
    localparam int SB = 4 - k;
    logic [20:0] dsh;
    logic ge;
    assign dsh = 21'(sd_den[k]) << SB;
    assign ge  = {5'b0, sd_rem[k]} >= dsh;
    always_ff @(posedge clk) begin
      sd_rem[k+1] <= ge ? 16'({5'b0, sd_rem[k]} - dsh) : sd_rem[k];
      sd_den[k+1] <= sd_den[k];
      sd_q[k+1]   <= {sd_q[k][3:0], ge};
    end
  end

  logic [4:0] st_dl [1:SD_DELAY];
  always_ff @(posedge clk) begin
    st_dl[1] <= sd_q[5];
    for (int j = 2; j <= SD_DELAY; j++) begin
      st_dl[j] <= st_dl[j-1];
    end
  end

  // Lamp halo and core share the offset to the light.
  logic [7:0] halo_add, core_add;

  lfps_shape #(
    .RADIUS (HALO_R),
    .PEAK   (HALO_PEAK),
    .IS_HEX (1'b0),
    .RECIP  (HALO_RECIP)
  ) u_halo (
    .clk (clk),
    .dx  (c_ldx),
    .dy  (c_ldy),
    .add (halo_add)
  );

  lfps_shape #(
    .RADIUS (CORE_R),
    .PEAK   (CORE_PEAK),
    .IS_HEX (1'b0),
    .RECIP  (CORE_RECIP)
  ) u_core (
    .clk (clk),
    .dx  (c_ldx),
    .dy  (c_ldy),
    .add (core_add)
  );

  // Ghosts sit at G = C + s (C - L) on the line through the screen centre.
  logic [7:0] gh_add [GHOST_SLOTS];

  for (genvar i = 0; i < GHOST_SLOTS; i++) begin : g_ghost
    if (i < NG) begin : g_on
      localparam logic signed [9:0] S_V = 10'(GHOST_S[i]);
      offset_t gp_x, gp_y, gdx, gdy;
      always_ff @(posedge clk) begin
        gp_x <= DW'(ldx * S_V);
        gp_y <= DW'(ldy * S_V);
        gdx  <= b_px - (CXC_V + gp_x);
        gdy  <= b_py - (CYC_V + gp_y);
      end

      lfps_shape #(
        .RADIUS (GHOST_R[i]),
        .PEAK   (GHOST_PEAK[i]),
        .IS_HEX (GHOST_HEX[i]),
        .RECIP  (GHOST_RECIP[i])
      ) u_shape (
        .clk (clk),
        .dx  (gdx),
        .dy  (gdy),
        .add (gh_add[i])
      );
    end else begin : g_off
      assign gh_add[i] = '0;
    end
  end

  // Pixel data rides alongside the shape units.
  item_t it_dl [1:SHAPE_LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= SHAPE_LAT; j++) begin
        it_dl[j] <= '0;
      end
    end else begin
      it_dl[1] <= c_item;
      for (int j = 2; j <= SHAPE_LAT; j++) begin
        it_dl[j] <= it_dl[j-1];
      end
    end
  end

  // Sum stage 1: lamp and streak on the base, ghosts on their own. Off-screen
  // pixels keep their base value.
  item_t e1_item;
  logic [9:0] e1_lamp;
  logic [10:0] e1_gh;
  logic [10:0] gh_sum;

  always_comb begin
    gh_sum = '0;
    for (int i = 0; i < GHOST_SLOTS; i++) begin
      gh_sum = gh_sum + 11'(gh_add[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_item <= '0;
    end else begin
      e1_item <= it_dl[SHAPE_LAT];
    end
    if (it_dl[SHAPE_LAT].on) begin
      e1_lamp <= 10'(it_dl[SHAPE_LAT].base) + 10'(halo_add) + 10'(core_add)
                 + 10'(st_dl[SD_DELAY]);
      e1_gh   <= gh_sum;
    end else begin
      e1_lamp <= 10'(it_dl[SHAPE_LAT].base);
      e1_gh   <= '0;
    end
  end

  // Sum stage 2: total and saturation.
  logic [11:0] total;
  assign total = 12'(e1_lamp) + 12'(e1_gh);

  always_ff @(posedge clk) begin
    out_x     <= e1_item.x;
    out_y     <= e1_item.y;
    out_value <= (total > 12'd255) ? 8'hFF : total[7:0];
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= e1_item.valid;
    end
  end

  // Every accepted transaction leaves the pipeline exactly once, on time.
  a_valid_latency: assert property (@(posedge clk) disable iff (rst)
    a_item.valid |-> ##(PIPE_LAT - 1) done)
    else $error("pixel transaction did not complete at the expected latency");

  // Off-screen pixels pass their base value through unchanged.
  a_offscreen_pass: assert property (@(posedge clk) disable iff (rst)
    (e1_item.valid && !e1_item.on) |=> (out_value == $past(e1_item.base)))
    else $error("off-screen pixel value was modified");

  // Light is only ever added, so the result never drops below the base.
  a_no_darken: assert property (@(posedge clk) disable iff (rst)
    e1_item.valid |=> (done && (out_value >= $past(e1_item.base))))
    else $error("shaded value fell below the base value");

endmodule

/* test/lens_flare_pixel_shader_tb.sv */
// Self-checking testbench for the lens flare pixel shader: directed and random pixels.
`timescale 1ns / 100ps

module lens_flare_pixel_shader_tb;
  import lfps_pkg::*;

  // Screen size of the block as instantiated, and the ghost placement and shape table.
  localparam int SCR_W = 640;
  localparam int SCR_H = 480;
  localparam int N_GHOSTS = 6;
  localparam int SUBPIX = 4096;
  localparam int SQRT3_HALF = 56756;
  localparam int GH_OFFSET [N_GHOSTS] = '{56, 115, 179, 256, 328, 397};
  localparam int GH_RADIUS [N_GHOSTS] = '{10, 16, 8, 22, 11, 7};
  localparam int GH_BRIGHT [N_GHOSTS] = '{90, 55, 70, 40, 50, 80};
  localparam bit GH_IS_HEX [N_GHOSTS] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  // Allowance after the last expected result, longer than the pipeline depth.
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [9:0] x;
    logic [8:0] y;
    logic [7:0] value;
  } shaded_pixel_t;

  // The scoreboard holds its own copy of the light position and predicts the
  // shaded value of every pixel transaction the block accepts. Expectations
  // are kept in order, since the pipeline never reorders or drops pixels.
  class flare_scoreboard;
    longint unsigned light_x;
    longint unsigned light_y;
    shaded_pixel_t shaded_q[$];
    int mismatches;
    int checked;
    int saturated;

    function new();
      light_x = 5120;
      light_y = 3840;
      mismatches = 0;
      checked = 0;
      saturated = 0;
    endfunction

    function void set_light(cfg_reg_t idx, logic [13:0] data);
      if (idx == REG_LIGHT_X) light_x = data;
      else light_y = data[12:0];
    endfunction

    function int pending();
      return shaded_q.size();
    endfunction

    static function longint absval(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // Bitwise integer square root, floor of the true root.
    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned one;
      root = 0;
      one = 64'd1 << 62;
      while (one > v) one = one >> 2;
      while (one != 0) begin
        if (v >= root + one) begin
          v = v - (root + one);
          root = (root >> 1) + one;
        end else begin
          root = root >> 1;
        end
        one = one >> 2;
      end
      return root;
    endfunction

    // Quadratic falloff (1 - d)^2 scaled by the peak, d in Q0.16.
    static function longint unsigned fade(longint unsigned peak, longint unsigned d);
      longint unsigned t;
      if (d > 65535) d = 65535;
      t = 65536 - d;
      return (peak * t * t) >> 32;
    endfunction

    static function longint unsigned disc_light(longint dx, longint dy, longint r,
                                                longint unsigned peak);
      longint lim;
      longint unsigned r2;
      longint unsigned q;
      lim = r * SUBPIX;
      if (absval(dx) >= lim || absval(dy) >= lim) return 0;
      r2 = dx * dx + dy * dy;
      if (r2 >= lim * lim) return 0;
      q = (r2 * 256) / (r * r);
      return fade(peak, int_sqrt(q));
    endfunction

    // Hexagon: the distance is the largest of the edge-normal projections, one per pair of opposite edges.
    static function longint unsigned hex_light(longint dx, longint dy, longint r,
                                               longint unsigned peak);
      longint lim;
      longint m;
      longint b;
      longint c;
      lim = r * SUBPIX;
      if (absval(dx) >= lim || absval(dy) >= 2 * lim) return 0;
      m = absval(dx) * 65536;
      b = absval(dx * 32768 + dy * SQRT3_HALF);
      c = absval(-dx * 32768 + dy * SQRT3_HALF);
      if (b > m) m = b;
      if (c > m) m = c;
      if (m >= lim * 65536) return 0;
      return fade(peak, m / lim);
    endfunction

    // Horizontal streak on the rows around the lamp, fading with column distance.
    function longint unsigned streak_light(longint x, longint y);
      longint ly;
      longint e;
      longint f;
      ly = light_y;
      if (y < (ly >> 4) - 3 || y > ((ly + 15) >> 4) + 3) return 0;
      e = 56 - absval(16 * y + 8 - ly);
      f = absval(16 * x + 8 - longint'(light_x));
      return (18 * e * e) / (7 * (448 + f));
    endfunction

    function shaded_pixel_t shade(logic [9:0] x, logic [8:0] y, logic [7:0] base);
      shaded_pixel_t res;
      longint unsigned total;
      longint px;
      longint py;
      longint lx;
      longint ly;
      longint gx;
      longint gy;
      total = base;
      if (x < SCR_W && y < SCR_H) begin
        px = SUBPIX * longint'(x) + SUBPIX / 2;
        py = SUBPIX * longint'(y) + SUBPIX / 2;
        lx = longint'(light_x) * 256;
        ly = longint'(light_y) * 256;
        total += disc_light(px - lx, py - ly, 38, 70);
        total += disc_light(px - lx, py - ly, 14, 220);
        total += streak_light(x, y);
        for (int i = 0; i < N_GHOSTS; i++) begin
          gx = SCR_W * 8 * 256 + GH_OFFSET[i] * (SCR_W * 8 - longint'(light_x));
          gy = SCR_H * 8 * 256 + GH_OFFSET[i] * (SCR_H * 8 - longint'(light_y));
          if (GH_IS_HEX[i])
            total += hex_light(px - gx, py - gy, GH_RADIUS[i], GH_BRIGHT[i]);
          else
            total += disc_light(px - gx, py - gy, GH_RADIUS[i], GH_BRIGHT[i]);
        end
      end
      if (total > 255) total = 255;
      res.x = x;
      res.y = y;
      res.value = total[7:0];
      return res;
    endfunction

    function void note_pixel(logic [9:0] x, logic [8:0] y, logic [7:0] base);
      shaded_q.push_back(shade(x, y, base));
    endfunction

    function void check_result(logic [9:0] x, logic [8:0] y, logic [7:0] value);
      shaded_pixel_t exp_px;
      checked++;
      if (shaded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result x=%0d y=%0d value=%0d", x, y, value);
        return;
      end
      exp_px = shaded_q.pop_front();
      if (value == 8'd255) saturated++;
      if (x !== exp_px.x || y !== exp_px.y || value !== exp_px.value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected x=%0d y=%0d value=%0d, got x=%0d y=%0d value=%0d",
                   exp_px.x, exp_px.y, exp_px.value, x, y, value);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [9:0]  pixel_x = '0;
  logic [8:0]  pixel_y = '0;
  logic [7:0]  base_value = '0;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_LIGHT_X;
  logic [13:0] cfg_data = '0;
  logic        done;
  logic [9:0]  out_x;
  logic [8:0]  out_y;
  logic [7:0]  out_value;

  flare_scoreboard flare_sb = new();
  bit idle_enable = 1'b1;
  int pixels_sent = 0;
  int light_settings = 1;

  always #5 clk = ~clk;

  lens_flare_pixel_shader i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .base_value(base_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .out_x(out_x), .out_y(out_y), .out_value(out_value)
  );

  // Both monitors sample the values that were stable before the edge, so the
  // outcome does not depend on the order of processes within the time step.
  always @(posedge clk) begin
    if (!rst && start && !busy) flare_sb.note_pixel(pixel_x, pixel_y, base_value);
    if (!rst && done) flare_sb.check_result(out_x, out_y, out_value);
  end

  // Present one pixel, possibly after a random idle gap, and hold it until the
  // block takes the transaction. Start stays high between back-to-back pixels.
  task automatic send_pixel(int x, int y, int base);
    while (idle_enable && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pixel_x <= x[9:0];
    pixel_y <= y[8:0];
    base_value <= base[7:0];
    @(posedge clk);
    while (busy) @(posedge clk);
    pixels_sent++;
  endtask

  // Registers are only written with the pipeline empty. Every pixel yields a
  // result, so an empty scoreboard means nothing is left in flight.
  task automatic write_light(int lx, int ly);
    start <= 1'b0;
    @(posedge clk);
    while (flare_sb.pending() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_LIGHT_X;
    cfg_data <= lx[13:0];
    @(posedge clk);
    flare_sb.set_light(REG_LIGHT_X, lx[13:0]);
    cfg_index <= REG_LIGHT_Y;
    cfg_data <= ly[13:0];
    @(posedge clk);
    flare_sb.set_light(REG_LIGHT_Y, ly[13:0]);
    cfg_we <= 1'b0;
    light_settings++;
  endtask

  function automatic int clip(int v, int hi);
    return (v < 0) ? 0 : (v > hi) ? hi : v;
  endfunction

  // Random pixels are aimed mostly at the lamp, its streak rows and the
  // ghosts, where the flare actually adds light; the rest cover the full
  // field ranges, off-screen coordinates included.
  task automatic random_pixel();
    int kind;
    int cx;
    int cy;
    int g;
    kind = $urandom_range(9);
    cx = flare_sb.light_x / 16;
    cy = flare_sb.light_y / 16;
    if (kind <= 3) begin
      send_pixel(clip(cx + $urandom_range(100) - 50, 1023),
                 clip(cy + $urandom_range(100) - 50, 511), $urandom_range(255));
    end else if (kind <= 6) begin
      g = $urandom_range(N_GHOSTS - 1);
      cx = (SCR_W * 8 * 256 + GH_OFFSET[g] * (SCR_W * 8 - int'(flare_sb.light_x))) / SUBPIX;
      cy = (SCR_H * 8 * 256 + GH_OFFSET[g] * (SCR_H * 8 - int'(flare_sb.light_y))) / SUBPIX;
      send_pixel(clip(cx + $urandom_range(60) - 30, 1023),
                 clip(cy + $urandom_range(60) - 30, 511), $urandom_range(255));
    end else begin
      send_pixel($urandom_range(1023), $urandom_range(511), $urandom_range(255));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed pixels with the light at its reset position, screen center.
    send_pixel(0, 0, 0);
    send_pixel(639, 479, 255);
    send_pixel(640, 0, 17);          // just off the right edge
    send_pixel(0, 480, 200);         // just below the bottom edge
    send_pixel(1023, 511, 255);      // largest field values, off screen
    send_pixel(320, 240, 0);         // lamp center, core near full strength
    send_pixel(320, 240, 255);       // lamp center, saturated
    send_pixel(357, 240, 0);         // near the rim of the halo
    send_pixel(600, 240, 3);         // streak far along the row
    send_pixel(320, 243, 0);         // lowest streak row below the lamp
    send_pixel(320, 236, 0);         // just above the top streak row
    send_pixel(319, 239, 128);

    // Light in the upper left corner: only the three inner ghosts land on screen.
    write_light(0, 0);
    send_pixel(0, 0, 0);
    send_pixel(2, 1, 100);
    for (int g = 0; g < N_GHOSTS; g++)
      send_pixel(clip((SCR_W * 8 * 256 + GH_OFFSET[g] * SCR_W * 8) / SUBPIX, 1023),
                 clip((SCR_H * 8 * 256 + GH_OFFSET[g] * SCR_H * 8) / SUBPIX, 511), 9);
    // Light at the top of the register ranges, far off screen.
    write_light(16383, 16383);
    send_pixel(639, 479, 0);
    send_pixel(1023, 511, 0);

    // Random phases at changing light positions, extremes included.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: write_light(5120, 3840);
        1: write_light(10239, 7679);
        2: write_light(0, 7679);
        3: write_light(10239, 0);
        default: write_light($urandom_range(16383), $urandom_range(16383));
      endcase
      // One phase runs back to back with no idle cycles at all.
      idle_enable = (phase != 3);
      repeat (205) random_pixel();
    end
    idle_enable = 1'b1;

    start <= 1'b0;
    @(posedge clk);
    while (flare_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Shaded %0d pixels under %0d light positions, %0d results saturated at 255.",
             pixels_sent, light_settings, flare_sb.saturated);
    $display("Checked %0d results, %0d mismatches.", flare_sb.checked, flare_sb.mismatches);
    if (flare_sb.mismatches == 0 && flare_sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: far beyond the length of a full run.
  initial begin
    #5000000;
    $display("ERROR: timeout with %0d results outstanding", flare_sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* files.f */
sv/lfps_pkg.sv
sv/lfps_shape.sv
sv/lens_flare_pixel_shader.sv
test/lens_flare_pixel_shader_tb.sv
